### hw/rtl/lms_weight_error_update_top_defines.svh
// assertion macros for the checker file
`ifndef LMS_WEIGHT_ERROR_UPDATE_TOP_DEFINES_SVH
`define LMS_WEIGHT_ERROR_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LMSWU_AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LMSWU_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lmswu_pkg.sv
package lmswu_pkg;

	localparam logic signed [31:0] WEIGHT_ONE = 32'sd16777216;
	localparam logic signed [19:0] X_MAX      = 20'sd524287;
	localparam logic signed [19:0] X_MIN      = -20'sd524288;
	localparam logic signed [31:0] W_MAX      = 32'sh7FFFFFFF;
	localparam logic signed [31:0] W_MIN      = 32'sh80000000;

	localparam logic [4:0]  RST_FILTER_LENGTH = 5'd16;
	localparam logic [3:0]  RST_MODEL_LENGTH  = 4'd10;
	localparam logic [15:0] RST_STEP_SIZE     = 16'd655;

	// rounding offsets preloaded into the accumulator
	localparam logic [63:0] RND_12 = 64'd2048;
	localparam logic [63:0] RND_14 = 64'd8192;
	localparam logic [63:0] RND_16 = 64'd32768;
	localparam logic [63:0] RND_24 = 64'd8388608;

	typedef enum logic [1:0] {
		REG_FILTER_LENGTH = 2'd0,
		REG_MODEL_LENGTH  = 2'd1,
		REG_STEP_SIZE     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               issue;
		logic               shl;
		logic               load;
		logic [63:0]        load_val;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mac_ctl_t;

	// moving-average coefficients, q2.14
	function automatic logic signed [15:0] ma_coef(input logic [3:0] k);
		logic signed [15:0] c;
		case (k)
			4'd0:    c = 16'sd16384;
			4'd1:    c = 16'sd13107;
			4'd2:    c = 16'sd13107;
			4'd3:    c = -16'sd11469;
			4'd4:    c = 16'sd9830;
			4'd5:    c = -16'sd8192;
			4'd6:    c = 16'sd6554;
			4'd7:    c = -16'sd4915;
			4'd8:    c = 16'sd3277;
			4'd9:    c = -16'sd1638;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/lmswu_mac.sv
module lmswu_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  lmswu_pkg::mac_ctl_t ctl,
	output logic [63:0]         acc,
	output logic                carry_seen
);

	logic signed [65:0] prod_s1;
	logic               vld_s1;
	logic               shl_s1;
	logic [63:0]        addend;
	logic [64:0]        sum;
	logic [63:0]        acc_q;
	logic               carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			shl_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			shl_s1 <= ctl.shl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= ctl.a * ctl.b;
		end
	end

	// high half of a split product lands 20 bits up
	assign addend = shl_s1 ? {prod_s1[43:0], 20'd0} : prod_s1[63:0];
	assign sum    = {1'b0, acc_q} + {1'b0, addend};

	// carry out only means something for the unsigned energy sum
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q   <= ctl.load_val;
			carry_q <= 1'b0;
		end else if (vld_s1) begin
			acc_q   <= sum[63:0];
			carry_q <= carry_q | sum[64];
		end
	end

	assign acc        = acc_q;
	assign carry_seen = carry_q;

endmodule

### hw/rtl/lms_weight_error_update_top.sv
// LMS weight update with a moving-average input model. Each sample word shifts
// u into the model line and the regressor x = sum b*u into the regressor line;
// on adapt words the block then returns the a priori error, the lead weight
// and the weight energy (all taken before the update) and updates every weight
// in use. All arithmetic runs through one shared 33x33 multiply-accumulate
// unit, one product per cycle, so the block takes one word at a time; each
// tap of the weight update chains three products (x*e, then the step size
// times both halves of the rounded term). Weights sit in a single-port
// memory with one valid bit per entry, so reset and a new trial need no
// clearing pass. Lengths of 0 act as 1 and lengths above the maximum act as
// the maximum. Configuration is to be written while idle; the block itself
// does not enforce it.
module lms_weight_error_update_top #(
	parameter int MAX_FILTER_TAPS = 16,
	parameter int MAX_MODEL_TAPS  = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] source_sample,
	input  logic signed [15:0] noise_sample,
	input  logic               new_trial,
	input  logic               adapt,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] error_value,
	output logic signed [31:0] lead_weight,
	output logic [31:0]        weight_energy
);

	localparam int IDX_W  = (MAX_FILTER_TAPS > 1) ? $clog2(MAX_FILTER_TAPS) : 1;
	localparam int MIDX_W = (MAX_MODEL_TAPS > 1) ? $clog2(MAX_MODEL_TAPS) : 1;
	localparam int CNT_W  = (IDX_W > MIDX_W) ? IDX_W : MIDX_W;
	localparam int FL_W   = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

	typedef enum logic [20:0] {
		S_IDLE   = 21'h000001,
		S_MA     = 21'h000002,
		S_MA_W1  = 21'h000004,
		S_MA_W2  = 21'h000008,
		S_X      = 21'h000010,
		S_ERR    = 21'h000020,
		S_ERR_W1 = 21'h000040,
		S_ERR_W2 = 21'h000080,
		S_E      = 21'h000100,
		S_NRG    = 21'h000200,
		S_NRG_W1 = 21'h000400,
		S_NRG_W2 = 21'h000800,
		S_N      = 21'h001000,
		S_U_RD   = 21'h002000,
		S_U_MUL  = 21'h004000,
		S_U_ACC  = 21'h008000,
		S_U_HI   = 21'h010000,
		S_U_LO   = 21'h020000,
		S_U_W1   = 21'h040000,
		S_U_WR   = 21'h080000,
		S_OUT    = 21'h100000
	} state_t;

	typedef enum logic [1:0] {
		OP_MA  = 2'd0,
		OP_ERR = 2'd1,
		OP_NRG = 2'd2,
		OP_XE  = 2'd3
	} op_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] f_last, m_last;
	logic [FL_W-1:0]  flen_x;

	logic [4:0]  flen_q;
	logic [3:0]  mlen_q;
	logic [15:0] beta_q;

	logic signed [15:0] mline_q [MAX_MODEL_TAPS];
	logic signed [19:0] rline_q [MAX_FILTER_TAPS];
	logic signed [31:0] wmem [MAX_FILTER_TAPS];
	logic [MAX_FILTER_TAPS-1:0] wv_q;

	logic               accept;
	logic               fe;
	op_t                fe_op;
	logic               ld;
	logic [63:0]        ld_val;
	logic [63:0]        err_init;

	logic               fe_s1;
	op_t                op_s1;
	logic               first_s1;
	logic signed [31:0] w_data_s1;
	logic               w_ok_s1;
	logic signed [19:0] x_s1;
	logic signed [15:0] m_s1;
	logic signed [15:0] c_s1;
	logic signed [31:0] w_val;

	logic signed [15:0] v_q;
	logic               adapt_q;
	logic signed [31:0] e_q;
	logic signed [31:0] lead_q;
	logic [31:0]        nrg_q;
	logic [19:0]        tlo_q;

	lmswu_pkg::mac_ctl_t mac_ctl;
	logic [63:0]         acc;
	logic                carry_seen;

	logic signed [49:0] x_full;
	logic signed [19:0] x_sat;
	logic signed [51:0] e_full;
	logic signed [31:0] e_sat;
	logic signed [47:0] d_full;
	logic signed [49:0] w_diff;
	logic signed [31:0] w_new;
	logic [31:0]        nrg_res;

	logic               res_valid_q;
	logic signed [31:0] res_err_q;
	logic signed [31:0] res_lead_q;
	logic [31:0]        res_nrg_q;
	logic               res_load;

	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && (state_q == S_IDLE);

	// effective last tap index of each pass
	assign flen_x = FL_W'(flen_q);
	always_comb begin
		if (flen_x == '0) begin
			f_last = '0;
		end else if (flen_x > FL_W'(MAX_FILTER_TAPS)) begin
			f_last = CNT_W'(MAX_FILTER_TAPS - 1);
		end else begin
			f_last = CNT_W'(flen_x - FL_W'(1));
		end
		if (mlen_q == '0) begin
			m_last = '0;
		end else if (mlen_q > 4'(MAX_MODEL_TAPS)) begin
			m_last = CNT_W'(MAX_MODEL_TAPS - 1);
		end else begin
			m_last = CNT_W'(mlen_q - 4'd1);
		end
	end

	assign err_init = {{12{v_q[15]}}, v_q, 36'd0} + lmswu_pkg::RND_12;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		fe      = 1'b0;
		fe_op   = OP_MA;
		ld      = 1'b0;
		ld_val  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					state_d = S_MA;
					idx_d   = '0;
					ld      = 1'b1;
					ld_val  = lmswu_pkg::RND_14;
				end
			end
			S_MA: begin
				fe    = 1'b1;
				fe_op = OP_MA;
				if (idx_q == m_last) begin
					state_d = S_MA_W1;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			S_MA_W1: state_d = S_MA_W2;
			S_MA_W2: state_d = S_X;
			S_X: begin
				idx_d = '0;
				if (adapt_q) begin
					state_d = S_ERR;
					ld      = 1'b1;
					ld_val  = err_init;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				fe    = 1'b1;
				fe_op = OP_ERR;
				if (idx_q == f_last) begin
					state_d = S_ERR_W1;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			S_ERR_W1: state_d = S_ERR_W2;
			S_ERR_W2: state_d = S_E;
			S_E: begin
				state_d = S_NRG;
				idx_d   = '0;
				ld      = 1'b1;
				ld_val  = lmswu_pkg::RND_24;
			end
			S_NRG: begin
				fe    = 1'b1;
				fe_op = OP_NRG;
				if (idx_q == f_last) begin
					state_d = S_NRG_W1;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			S_NRG_W1: state_d = S_NRG_W2;
			S_NRG_W2: state_d = S_N;
			S_N: begin
				state_d = S_U_RD;
				idx_d   = '0;
			end
			S_U_RD: begin
				fe      = 1'b1;
				fe_op   = OP_XE;
				ld      = 1'b1;
				ld_val  = lmswu_pkg::RND_12;
				state_d = S_U_MUL;
			end
			S_U_MUL: state_d = S_U_ACC;
			S_U_ACC: state_d = S_U_HI;
			S_U_HI: begin
				ld      = 1'b1;
				ld_val  = lmswu_pkg::RND_16;
				state_d = S_U_LO;
			end
			S_U_LO: state_d = S_U_W1;
			S_U_W1: state_d = S_U_WR;
			S_U_WR: begin
				if (idx_q == f_last) begin
					state_d = S_OUT;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_U_RD;
				end
			end
			S_OUT: begin
				if (!res_valid_q || !result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			fe_s1   <= 1'b0;
			flen_q  <= lmswu_pkg::RST_FILTER_LENGTH;
			mlen_q  <= lmswu_pkg::RST_MODEL_LENGTH;
			beta_q  <= lmswu_pkg::RST_STEP_SIZE;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fe_s1   <= fe;
			if (cfg_we) begin
				unique case (cfg_index)
					lmswu_pkg::REG_FILTER_LENGTH: flen_q <= cfg_data[4:0];
					lmswu_pkg::REG_MODEL_LENGTH:  mlen_q <= cfg_data[3:0];
					lmswu_pkg::REG_STEP_SIZE:     beta_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// sample lines and weight valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_MODEL_TAPS; i++) begin
				mline_q[i] <= '0;
			end
			for (int i = 0; i < MAX_FILTER_TAPS; i++) begin
				rline_q[i] <= '0;
			end
			wv_q <= '0;
		end else begin
			if (accept) begin
				for (int i = MAX_MODEL_TAPS - 1; i > 0; i--) begin
					mline_q[i] <= new_trial ? 16'sd0 : mline_q[i-1];
				end
				mline_q[0] <= source_sample;
				if (new_trial) begin
					for (int i = 0; i < MAX_FILTER_TAPS; i++) begin
						rline_q[i] <= '0;
					end
					wv_q <= '0;
				end
			end
			if (state_q == S_X) begin
				for (int i = MAX_FILTER_TAPS - 1; i > 0; i--) begin
					rline_q[i] <= rline_q[i-1];
				end
				rline_q[0] <= x_sat;
			end
			if (state_q == S_U_WR) begin
				wv_q[idx_q[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// weight memory, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_U_WR) begin
			wmem[idx_q[IDX_W-1:0]] <= w_new;
		end
		if (fe && (fe_op != OP_MA)) begin
			w_data_s1 <= wmem[idx_q[IDX_W-1:0]];
		end
	end

	// operand fetch stage
	always_ff @(posedge clk) begin
		if (fe) begin
			op_s1    <= fe_op;
			first_s1 <= (idx_q == '0);
			if (fe_op == OP_MA) begin
				m_s1 <= mline_q[idx_q[MIDX_W-1:0]];
				c_s1 <= lmswu_pkg::ma_coef(4'(idx_q[MIDX_W-1:0]));
			end else begin
				w_ok_s1 <= wv_q[idx_q[IDX_W-1:0]];
				x_s1    <= rline_q[idx_q[IDX_W-1:0]];
			end
		end
	end

	// an entry never written since the last clear reads as one
	assign w_val = w_ok_s1 ? w_data_s1 : lmswu_pkg::WEIGHT_ONE;

	always_comb begin
		mac_ctl          = '0;
		mac_ctl.load     = ld;
		mac_ctl.load_val = ld_val;
		if (fe_s1) begin
			mac_ctl.issue = 1'b1;
			unique case (op_s1)
				OP_MA: begin
					mac_ctl.a = 33'(c_s1);
					mac_ctl.b = 33'(m_s1);
				end
				OP_ERR: begin
					mac_ctl.a = 33'(w_val);
					mac_ctl.b = 33'(x_s1);
				end
				OP_NRG: begin
					mac_ctl.a = 33'(w_val);
					mac_ctl.b = 33'(w_val);
				end
				OP_XE: begin
					mac_ctl.a = 33'(x_s1);
					mac_ctl.b = 33'(e_q);
				end
				default: ;
			endcase
		end
		// rounded x*e split in two halves, each times the step size
		if (state_q == S_U_HI) begin
			mac_ctl.issue = 1'b1;
			mac_ctl.shl   = 1'b1;
			mac_ctl.a     = 33'($signed(acc[51:32]));
			mac_ctl.b     = {17'd0, beta_q};
		end
		if (state_q == S_U_LO) begin
			mac_ctl.issue = 1'b1;
			mac_ctl.a     = {13'd0, tlo_q};
			mac_ctl.b     = {17'd0, beta_q};
		end
	end

	lmswu_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.acc        (acc),
		.carry_seen (carry_seen)
	);

	always_comb begin
		x_full = $signed(acc[63:14]);
		if (x_full > 50'(lmswu_pkg::X_MAX)) begin
			x_sat = lmswu_pkg::X_MAX;
		end else if (x_full < 50'(lmswu_pkg::X_MIN)) begin
			x_sat = lmswu_pkg::X_MIN;
		end else begin
			x_sat = x_full[19:0];
		end

		e_full = $signed(acc[63:12]);
		if (e_full > 52'(lmswu_pkg::W_MAX)) begin
			e_sat = lmswu_pkg::W_MAX;
		end else if (e_full < 52'(lmswu_pkg::W_MIN)) begin
			e_sat = lmswu_pkg::W_MIN;
		end else begin
			e_sat = e_full[31:0];
		end

		d_full = $signed(acc[63:16]);
		w_diff = 50'(w_val) - 50'(d_full);
		if (w_diff > 50'(lmswu_pkg::W_MAX)) begin
			w_new = lmswu_pkg::W_MAX;
		end else if (w_diff < 50'(lmswu_pkg::W_MIN)) begin
			w_new = lmswu_pkg::W_MIN;
		end else begin
			w_new = w_diff[31:0];
		end

		nrg_res = (carry_seen || (acc[63:56] != 8'd0)) ? 32'hFFFFFFFF : acc[55:24];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q     <= noise_sample;
			adapt_q <= adapt;
		end
		if (fe_s1 && (op_s1 == OP_ERR) && first_s1) begin
			lead_q <= w_val;
		end
		if (state_q == S_E) begin
			e_q <= e_sat;
		end
		if (state_q == S_N) begin
			nrg_q <= nrg_res;
		end
		if (state_q == S_U_HI) begin
			tlo_q <= acc[31:12];
		end
	end

	// output register, the next word may come in while a result waits
	assign res_load = (state_q == S_OUT) && (!res_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_err_q  <= e_q;
			res_lead_q <= lead_q;
			res_nrg_q  <= nrg_q;
		end
	end

	assign result_valid  = res_valid_q;
	assign error_value   = res_err_q;
	assign lead_weight   = res_lead_q;
	assign weight_energy = res_nrg_q;

endmodule

### hw/rtl/lmswu_checker.sv
`include "lms_weight_error_update_top_defines.svh"

module lmswu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] error_value,
	input logic [31:0] lead_weight,
	input logic [31:0] weight_energy
);

	logic take;

	assign take = sample_valid && !sample_stall;

	// one word at a time
	`LMSWU_AST_NEXT(a_busy_after_take, take, sample_stall, "input not stalled after a word")

	// a result only shows up as the sequencer goes back to idle
	`LMSWU_AST_SAME(a_result_at_idle, $rose(result_valid), !sample_stall, "result while busy")

	// no result can rise in the cycle after a word is taken
	`LMSWU_AST_NEXT(a_no_early_result, take, !$rose(result_valid), "result too early")

	`LMSWU_AST_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(error_value) && $stable(lead_weight) && $stable(weight_energy), "stalled result changed")

endmodule

bind lms_weight_error_update_top lmswu_checker u_lmswu_checker (.*);
